// File: hdl/brbmr_pkg.sv
// Package: command codes and default sizes for the broadcast ring buffer.
`timescale 1ns / 1ps

package brbmr_pkg;

  localparam int DEPTH_DEF     = 512;
  localparam int CONSUMERS_DEF = 2;
  localparam int WORD_BITS_DEF = 64;

  localparam int FRAME_W = 64;
  localparam int AVAIL_W = 10;
  localparam int COUNT_W = 32;
  localparam int CMD_W   = 3;
  localparam int ID_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_ENABLE  = 3'd2,
    CMD_DISABLE = 3'd3,
    CMD_FLUSH   = 3'd4,
    CMD_DROPS   = 3'd5
  } cmd_t;

endpackage

// File: hdl/broadcast_ring_buffer_multi_reader.sv
// Broadcast ring buffer with one producer and several independent readers.
// The result strobe (done) is registered and comes in the cycle after the beat is taken.
// Throughput: one command per cycle; the ring is written at the accept edge
// and a pop reads it at the same edge, its word registered by the RAM port.
// busy is high only while rst is high. Synchronous reset clears head, tails,
// enables and drop counters; ring contents stay undefined until written.
`timescale 1ns / 1ps

module broadcast_ring_buffer_multi_reader
  import brbmr_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int CONSUMERS = CONSUMERS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command,
  input  logic [ID_W-1:0]    consumer_id,
  input  logic [FRAME_W-1:0] frame_data,
  output logic               done,
  output logic               frame_valid,
  output logic [FRAME_W-1:0] frame_out,
  output logic [AVAIL_W-1:0] available_count,
  output logic [COUNT_W-1:0] dropped_count,
  output logic [COUNT_W-1:0] head_count
);

  localparam int AW = $clog2(DEPTH);

  logic                 accept;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  assign busy   = rst;
  assign accept = start && !busy;

  brbmr_ctrl #(
    .DEPTH     (DEPTH),
    .CONSUMERS (CONSUMERS),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .consumer_id (consumer_id),
    .frame_data  (frame_data),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .done        (done),
    .pop_valid   (frame_valid),
    .avail       (available_count),
    .drops_rep   (dropped_count),
    .head        (head_count)
  );

  brbmr_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // zero the word when no pop was delivered
  assign frame_out = frame_valid ? FRAME_W'(mem_rdata) : '0;

endmodule

// File: hdl/brbmr_ram.sv
// Ring storage: one write port, one registered read port.
`timescale 1ns / 1ps

module brbmr_ram
  import brbmr_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/brbmr_ctrl.sv
// Head counter, per-reader state and result registers.
`timescale 1ns / 1ps

module brbmr_ctrl
  import brbmr_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int CONSUMERS = CONSUMERS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int AW       = $clog2(DEPTH),
  localparam int IW       = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [CMD_W-1:0]     command,
  input  logic [ID_W-1:0]      consumer_id,
  input  logic [FRAME_W-1:0]   frame_data,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [WORD_BITS-1:0] mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  output logic                 done,
  output logic                 pop_valid,
  output logic [AVAIL_W-1:0]   avail,
  output logic [COUNT_W-1:0]   drops_rep,
  output logic [COUNT_W-1:0]   head
);

  logic [COUNT_W-1:0] tail      [CONSUMERS];
  logic [COUNT_W-1:0] drops     [CONSUMERS];
  logic               en        [CONSUMERS];
  logic [COUNT_W-1:0] tail_next [CONSUMERS];
  logic [COUNT_W-1:0] drops_next[CONSUMERS];
  logic               en_next   [CONSUMERS];
  logic [COUNT_W-1:0] head_next;
  logic               pop_ok;
  logic               id_ok;
  logic [IW-1:0]      sel;
  logic [AVAIL_W-1:0] avail_calc;
  logic [COUNT_W-1:0] drops_calc;
  cmd_t               cmd;

  assign cmd   = cmd_t'(command);
  assign id_ok = 32'(consumer_id) < CONSUMERS;
  assign sel   = consumer_id[IW-1:0];

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    drops_next = drops;
    en_next    = en;
    pop_ok     = 1'b0;
    avail_calc = '0;
    drops_calc = '0;
    if (cmd == CMD_PUSH) begin
      // readers a full ring behind lose their oldest word
      for (int i = 0; i < CONSUMERS; i++) begin
        if (en[i] && ((head - tail[i]) >= COUNT_W'(DEPTH))) begin
          tail_next[i]  = head - COUNT_W'(DEPTH - 1);
          drops_next[i] = drops[i] + 1'b1;
        end
      end
      head_next = head + 1'b1;
    end else if (id_ok) begin
      case (cmd)
        CMD_POP: begin
          if (en[sel] && (tail[sel] != head)) begin
            pop_ok         = 1'b1;
            tail_next[sel] = tail[sel] + 1'b1;
          end
        end
        CMD_ENABLE: begin
          tail_next[sel]  = head;
          drops_next[sel] = '0;
          en_next[sel]    = 1'b1;
        end
        CMD_DISABLE: begin
          en_next[sel] = 1'b0;
        end
        CMD_FLUSH: begin
          tail_next[sel] = head;
        end
        CMD_DROPS: begin
          drops_next[sel] = '0;
        end
        default: begin
        end
      endcase
    end
    if (id_ok) begin
      drops_calc = (cmd == CMD_DROPS) ? drops[sel] : drops_next[sel];
      if (en_next[sel]) begin
        avail_calc = AVAIL_W'(head_next - tail_next[sel]);
      end
    end
  end

  assign mem_we    = accept && (cmd == CMD_PUSH);
  assign mem_waddr = head[AW-1:0];
  assign mem_wdata = frame_data[WORD_BITS-1:0];
  assign mem_re    = accept && pop_ok;
  assign mem_raddr = tail[sel][AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      done      <= 1'b0;
      pop_valid <= 1'b0;
      for (int i = 0; i < CONSUMERS; i++) begin
        tail[i]  <= '0;
        drops[i] <= '0;
        en[i]    <= 1'b0;
      end
    end else begin
      done <= accept;
      if (accept) begin
        head      <= head_next;
        tail      <= tail_next;
        drops     <= drops_next;
        en        <= en_next;
        pop_valid <= pop_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      avail     <= avail_calc;
      drops_rep <= drops_calc;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("result strobe missing after accepted beat");

  a_no_extra_done: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done) else $error("result strobe without accepted beat");

  a_push_head: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_PUSH)) |=> (head == $past(head) + 1'b1))
    else $error("head did not advance on push");

  a_pop_read: assert property (@(posedge clk) disable iff (rst)
    (done && pop_valid) |-> $past(mem_re))
    else $error("word delivered without a ring read");

  for (genvar g = 0; g < CONSUMERS; g++) begin : g_lag
    a_lag: assert property (@(posedge clk) disable iff (rst)
      en[g] |-> ((head - tail[g]) <= COUNT_W'(DEPTH)))
      else $error("reader lag exceeds ring depth");
  end

endmodule

// File: test/brbmr_ring_checker.sv
// Checker: predicts each command's result for the broadcast ring buffer and compares it.
`timescale 1ns / 1ps

module brbmr_ring_checker
  import brbmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [CMD_W-1:0]   command,
  input  logic [ID_W-1:0]    consumer_id,
  input  logic [FRAME_W-1:0] frame_data,
  input  logic               done,
  input  logic               frame_valid,
  input  logic [FRAME_W-1:0] frame_out,
  input  logic [AVAIL_W-1:0] available_count,
  input  logic [COUNT_W-1:0] dropped_count,
  input  logic [COUNT_W-1:0] head_count,
  output int                 mismatch_count,
  output int                 status_pending
);

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] word;
    logic [AVAIL_W-1:0] avail;
    logic [COUNT_W-1:0] drops;
    logic [COUNT_W-1:0] head;
  } ring_status_t;

  logic [FRAME_W-1:0] ring_words [DEPTH_DEF];
  logic [COUNT_W-1:0] write_ptr;
  logic [COUNT_W-1:0] read_ptr [CONSUMERS_DEF];
  logic               reader_on [CONSUMERS_DEF];
  logic [COUNT_W-1:0] drop_tally [CONSUMERS_DEF];
  ring_status_t       status_due [$];

  function automatic ring_status_t next_ring_status(input logic [CMD_W-1:0] c,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [FRAME_W-1:0] word);
    ring_status_t s;
    logic [COUNT_W-1:0] lag;
    logic in_range;
    int r;
    s = '0;
    in_range = (id < CONSUMERS_DEF);
    if (c == CMD_PUSH) begin
      // test every reader against the old head before the word lands
      for (r = 0; r < CONSUMERS_DEF; r++) begin
        lag = write_ptr - read_ptr[r];
        if (reader_on[r] && lag >= DEPTH_DEF) begin
          read_ptr[r] = write_ptr - COUNT_W'(DEPTH_DEF - 1);
          drop_tally[r] = drop_tally[r] + 1'b1;
        end
      end
      ring_words[write_ptr % DEPTH_DEF] = word;
      write_ptr = write_ptr + 1'b1;
    end else if (in_range) begin
      case (c)
        CMD_POP: begin
          if (reader_on[id] && read_ptr[id] != write_ptr) begin
            s.valid = 1'b1;
            s.word = ring_words[read_ptr[id] % DEPTH_DEF];
            read_ptr[id] = read_ptr[id] + 1'b1;
          end
        end
        CMD_ENABLE: begin
          read_ptr[id] = write_ptr;
          drop_tally[id] = '0;
          reader_on[id] = 1'b1;
        end
        CMD_DISABLE: reader_on[id] = 1'b0;
        CMD_FLUSH: read_ptr[id] = write_ptr;
        CMD_DROPS: begin
          // report the count from before the clear
          s.drops = drop_tally[id];
          drop_tally[id] = '0;
        end
        default: ;
      endcase
    end
    if (in_range) begin
      if (c != CMD_DROPS) s.drops = drop_tally[id];
      if (reader_on[id]) s.avail = AVAIL_W'(write_ptr - read_ptr[id]);
    end
    s.head = write_ptr;
    return s;
  endfunction

  task automatic check_field(input string field, input logic [FRAME_W-1:0] want,
                             input logic [FRAME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    ring_status_t want;
    int r;
    if (rst) begin
      write_ptr = '0;
      for (r = 0; r < CONSUMERS_DEF; r++) begin
        read_ptr[r] = '0;
        reader_on[r] = 1'b0;
        drop_tally[r] = '0;
      end
      status_due.delete();
    end else begin
      if (done) begin
        if (status_due.size() == 0) begin
          $display("%0t: result beat, expected none, actual head %0h", $time, head_count);
          mismatch_count++;
        end else begin
          want = status_due.pop_front();
          check_field("frame_valid", FRAME_W'(want.valid), FRAME_W'(frame_valid));
          check_field("frame_out", want.word, frame_out);
          check_field("available_count", FRAME_W'(want.avail), FRAME_W'(available_count));
          check_field("dropped_count", FRAME_W'(want.drops), FRAME_W'(dropped_count));
          check_field("head_count", FRAME_W'(want.head), FRAME_W'(head_count));
        end
      end
      if (start && !busy) begin
        status_due.push_back(next_ring_status(command, consumer_id, frame_data));
      end
    end
    status_pending = status_due.size();
  end

endmodule

// File: test/tb_broadcast_ring_buffer_multi_reader.sv
// Testbench top: drives command beats into the broadcast ring buffer and gives the verdict.
`timescale 1ns / 1ps

module tb_broadcast_ring_buffer_multi_reader;
  import brbmr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int MIXED_BEATS = 70;
  localparam int BURST_BEATS = 540;
  localparam int STALL_LIMIT = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [CMD_W-1:0]   command = CMD_PUSH;
  logic [ID_W-1:0]    consumer_id = '0;
  logic [FRAME_W-1:0] frame_data = '0;
  logic               busy;
  logic               done;
  logic               frame_valid;
  logic [FRAME_W-1:0] frame_out;
  logic [AVAIL_W-1:0] available_count;
  logic [COUNT_W-1:0] dropped_count;
  logic [COUNT_W-1:0] head_count;
  int                 mismatch_count;
  int                 status_pending;
  int                 idle_pct = 0;
  int                 stall_cycles = 0;

  always #10 clk = ~clk;

  broadcast_ring_buffer_multi_reader uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .consumer_id(consumer_id), .frame_data(frame_data),
    .done(done), .frame_valid(frame_valid), .frame_out(frame_out),
    .available_count(available_count), .dropped_count(dropped_count),
    .head_count(head_count)
  );

  brbmr_ring_checker ring_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .consumer_id(consumer_id), .frame_data(frame_data),
    .done(done), .frame_valid(frame_valid), .frame_out(frame_out),
    .available_count(available_count), .dropped_count(dropped_count),
    .head_count(head_count),
    .mismatch_count(mismatch_count), .status_pending(status_pending)
  );

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                           input logic [FRAME_W-1:0] d);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    command <= c;
    consumer_id <= id;
    frame_data <= d;
    taken = 1'b0;
    while (!taken) begin
      // busy follows rst, which only moves at a falling edge, so this is what the rising edge will see
      taken = !busy;
      @(negedge clk);
    end
  endtask

  task automatic send_random_beat();
    int pick;
    logic [CMD_W-1:0] c;
    logic [ID_W-1:0] id;
    pick = $urandom_range(99);
    if (pick < 40) c = CMD_PUSH;
    else if (pick < 72) c = CMD_POP;
    else if (pick < 80) c = CMD_ENABLE;
    else if (pick < 84) c = CMD_DISABLE;
    else if (pick < 89) c = CMD_FLUSH;
    else if (pick < 96) c = CMD_DROPS;
    else if (pick < 98) c = CMD_SPARE_6;
    else c = CMD_SPARE_7;
    if ($urandom_range(99) < 85) id = ID_W'($urandom_range(CONSUMERS_DEF - 1));
    else id = ID_W'($urandom_range(7));
    send_beat(c, id, {$urandom, $urandom});
  endtask

  initial begin
    int p;
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    send_beat(CMD_POP, 3'd0, '0);
    send_beat(CMD_PUSH, 3'd0, '0);
    send_beat(CMD_PUSH, 3'd1, '1);
    send_beat(CMD_DROPS, 3'd0, '0);
    send_beat(CMD_ENABLE, 3'd0, '0);
    send_beat(CMD_ENABLE, 3'd1, '0);
    send_beat(CMD_PUSH, 3'd0, 64'hA5A5_A5A5_A5A5_A5A5);
    send_beat(CMD_PUSH, 3'd7, 64'h5A5A_5A5A_5A5A_5A5A);
    send_beat(CMD_POP, 3'd0, '1);
    send_beat(CMD_POP, 3'd1, '0);
    send_beat(CMD_FLUSH, 3'd1, '0);
    send_beat(CMD_POP, 3'd1, '0);
    send_beat(CMD_POP, 3'd0, '0);
    send_beat(CMD_POP, 3'd0, '0);
    send_beat(CMD_DISABLE, 3'd1, '0);
    send_beat(CMD_POP, 3'd1, '0);
    send_beat(CMD_FLUSH, 3'd1, '0);
    send_beat(CMD_DROPS, 3'd1, '0);
    send_beat(CMD_ENABLE, 3'd7, '0);
    send_beat(CMD_POP, 3'd2, '0);
    send_beat(CMD_DROPS, 3'd6, '0);
    send_beat(CMD_SPARE_6, 3'd0, '1);
    send_beat(CMD_SPARE_7, 3'd1, '0);

    for (p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 85 : (p == 3) ? 26 : 0;
      for (n = 0; n < MIXED_BEATS; n++) send_random_beat();
      if (p == 0) begin
        // let both readers fall a full ring behind so the overrun path fires
        send_beat(CMD_ENABLE, 3'd0, '0);
        send_beat(CMD_ENABLE, 3'd1, '0);
        for (n = 0; n < BURST_BEATS; n++) begin
          if ($urandom_range(99) < 96) send_beat(CMD_PUSH, ID_W'($urandom_range(7)),
                                                 {$urandom, $urandom});
          else if ($urandom_range(1) == 0) send_beat(CMD_POP, 3'd0, '0);
          else send_beat(CMD_DROPS, 3'd1, '0);
        end
        send_beat(CMD_POP, 3'd1, '0);
        send_beat(CMD_DROPS, 3'd0, '0);
        send_beat(CMD_DROPS, 3'd1, '0);
      end
    end
    start <= 1'b0;

    while (status_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && status_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Abort when neither a command nor a result moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
